/* rtl/core/c1ks_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c1ks_pkg
// Shared types, tap masks and filter tables for the Crypto1 keystream engine.
// ----------------------------------------------------------------------------
package c1ks_pkg;

    localparam int unsigned HALF_W = 24;
    localparam int unsigned KEY_W  = 48;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned CNT_W  = 5;

    localparam logic [HALF_W-1:0] POLY_ODD  = 24'h29CE5C;
    localparam logic [HALF_W-1:0] POLY_EVEN = 24'h870804;

    localparam logic [31:0] FA0 = 32'h000F22C0;
    localparam logic [31:0] FA1 = 32'h0006C9C0;
    localparam logic [31:0] FA2 = 32'h0003C8B0;
    localparam logic [31:0] FA3 = 32'h0001E458;
    localparam logic [31:0] FA4 = 32'h0000D938;
    localparam logic [31:0] FC  = 32'hEC57E80A;

    typedef enum logic [1:0] {
        OP_INIT   = 2'd0,
        OP_NIBBLE = 2'd1,
        OP_BYTE   = 2'd2,
        OP_WORD   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_STEP = 2'd1,
        S_DONE = 2'd2
    } t_state;

    // two-layer nonlinear filter over bits 19..0 of the odd half
    function automatic logic filter_bit(input logic [HALF_W-1:0] v);
        logic [4:0] f;
        f[4] = FA0[{1'b0, v[3:0]}   + 5'd4];
        f[3] = FA1[{1'b0, v[7:4]}   + 5'd3];
        f[2] = FA2[{1'b0, v[11:8]}  + 5'd2];
        f[1] = FA3[{1'b0, v[15:12]} + 5'd1];
        f[0] = FA4[{1'b0, v[19:16]}];
        return FC[f];
    endfunction

    function automatic logic [DATA_W-1:0] byte_swap(input logic [DATA_W-1:0] d);
        return {d[7:0], d[15:8], d[23:16], d[31:24]};
    endfunction

endpackage
`default_nettype wire

/* rtl/core/crypto1_keystream_engine_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crypto1_keystream_engine_unit
// Crypto1 keystream generator, one LFSR step per clock.
//
// Input channel (i_in_valid / o_in_stall) takes an opcode, data bits and the
// encrypted-feed flag. Output channel (o_out_valid / i_out_stall) returns the
// keystream bits and the parity key bit, one beat per input beat.
// Configuration channel (i_cfg_valid / o_cfg_ready) writes the 48-bit key;
// it is always ready. The user must write it only while the engine is idle;
// the block does not enforce this. An init beat goes from idle straight to
// the done state; a step opcode first passes through the step state for 4,
// 8 or 32 LFSR steps through the shared filter and feedback parity. Input
// is taken again in the cycle after the result moves to the output register.
// Synchronous active-low reset clears the LFSR, key, state and output valid.
// When the receiver stalls, the output register holds its beat; a new item
// may still be accepted and stepped, and it waits until the register frees.
// ----------------------------------------------------------------------------
module crypto1_keystream_engine_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [47:0] i_cipher_key,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [1:0]  i_opcode,
    input  wire  [31:0] i_data_in,
    input  wire         i_encrypted_feed,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [31:0] o_keystream,
    output logic        o_parity_key
);

    c1ks_pkg::t_state                r_state;
    c1ks_pkg::t_state                n_state;
    c1ks_pkg::t_opcode               r_op;
    logic [c1ks_pkg::KEY_W-1:0]      r_key;
    logic [c1ks_pkg::HALF_W-1:0]     r_odd;
    logic [c1ks_pkg::HALF_W-1:0]     r_even;
    logic [c1ks_pkg::DATA_W-1:0]     r_data;
    logic [c1ks_pkg::DATA_W-1:0]     r_ks;
    logic [c1ks_pkg::CNT_W-1:0]      r_cnt;
    logic [c1ks_pkg::CNT_W-1:0]      r_cnt_max;
    logic                            r_enc;
    logic                            r_out_valid;
    logic [c1ks_pkg::DATA_W-1:0]     r_out_ks;
    logic                            r_out_par;

    logic                            in_fire;
    logic                            out_fire;
    logic                            in_stall;
    logic                            out_load;
    logic                            step_en;
    logic                            ks_bit;
    logic                            fb_bit;
    logic [c1ks_pkg::HALF_W-1:0]     key_odd;
    logic [c1ks_pkg::HALF_W-1:0]     key_even;
    logic [c1ks_pkg::DATA_W-1:0]     ks_aligned;
    c1ks_pkg::t_opcode               in_op;

    assign in_op    = c1ks_pkg::t_opcode'(i_opcode);
    assign in_fire  = i_in_valid && !in_stall;
    assign out_fire = r_out_valid && !i_out_stall;

    always_comb begin
        for (int j = 0; j < c1ks_pkg::HALF_W; j++) begin
            key_odd[j]  = r_key[(2 * j) ^ 7];
            key_even[j] = r_key[(2 * j + 1) ^ 7];
        end
    end

    assign ks_bit = c1ks_pkg::filter_bit(r_odd);
    assign fb_bit = (^(r_odd & c1ks_pkg::POLY_ODD)) ^ (^(r_even & c1ks_pkg::POLY_EVEN))
                  ^ r_data[0] ^ (r_enc & ks_bit);

    always_comb begin
        case (r_op)
            c1ks_pkg::OP_NIBBLE: ks_aligned = {28'd0, r_ks[31:28]};
            c1ks_pkg::OP_BYTE:   ks_aligned = {24'd0, r_ks[31:24]};
            c1ks_pkg::OP_WORD:   ks_aligned = c1ks_pkg::byte_swap(r_ks);
            default:             ks_aligned = r_ks;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            c1ks_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (in_op == c1ks_pkg::OP_INIT) ? c1ks_pkg::S_DONE
                                                           : c1ks_pkg::S_STEP;
                end
            end
            c1ks_pkg::S_STEP: begin
                if (r_cnt == r_cnt_max) begin
                    n_state = c1ks_pkg::S_DONE;
                end
            end
            c1ks_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = c1ks_pkg::S_IDLE;
                end
            end
            default: n_state = c1ks_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        in_stall = 1'b1;
        step_en  = 1'b0;
        out_load = 1'b0;
        case (r_state)
            c1ks_pkg::S_IDLE: in_stall = 1'b0;
            c1ks_pkg::S_STEP: step_en  = 1'b1;
            c1ks_pkg::S_DONE: out_load = !r_out_valid || !i_out_stall;
            default: in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= c1ks_pkg::S_IDLE;
            r_key       <= '0;
            r_odd       <= '0;
            r_even      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_key <= i_cipher_key;
            end
            if (in_fire && in_op == c1ks_pkg::OP_INIT) begin
                r_odd  <= key_odd;
                r_even <= key_even;
            end else if (step_en) begin
                r_odd  <= {r_even[c1ks_pkg::HALF_W-2:0], fb_bit};
                r_even <= r_odd;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op  <= in_op;
            r_enc <= i_encrypted_feed;
            r_cnt <= '0;
            r_ks  <= '0;
            r_data <= (in_op == c1ks_pkg::OP_WORD) ? c1ks_pkg::byte_swap(i_data_in)
                                                   : i_data_in;
            case (in_op)
                c1ks_pkg::OP_NIBBLE: r_cnt_max <= 5'd3;
                c1ks_pkg::OP_BYTE:   r_cnt_max <= 5'd7;
                default:             r_cnt_max <= 5'd31;
            endcase
        end else if (step_en) begin
            r_cnt  <= r_cnt + 5'd1;
            r_data <= {1'b0, r_data[c1ks_pkg::DATA_W-1:1]};
            r_ks   <= {ks_bit, r_ks[c1ks_pkg::DATA_W-1:1]};
        end
        if (out_load) begin
            r_out_ks  <= ks_aligned;
            r_out_par <= ks_bit;
        end
    end

    assign o_cfg_ready  = 1'b1;
    assign o_in_stall   = in_stall;
    assign o_out_valid  = r_out_valid;
    assign o_keystream  = r_out_ks;
    assign o_parity_key = r_out_par;

    a_init_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && in_op == c1ks_pkg::OP_INIT |=> r_state == c1ks_pkg::S_DONE && r_ks == '0)
        else $error("init beat did not go straight to result with zero keystream");

    a_step_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && in_op != c1ks_pkg::OP_INIT |=> r_state == c1ks_pkg::S_STEP && r_cnt == '0)
        else $error("step opcode did not start stepping from count zero");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == c1ks_pkg::S_STEP |-> r_cnt <= r_cnt_max)
        else $error("step count ran past its limit");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == c1ks_pkg::S_DONE && r_out_valid && i_out_stall
        |=> r_state == c1ks_pkg::S_DONE && r_out_valid)
        else $error("finished result left while output register was held");

endmodule
`default_nettype wire
